/* hw/rtl/nnrn_pkg.sv */
`timescale 1ns / 1ps

package nnrn_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int MAX_PLANES  = 3;
  localparam int MAX_BATCH   = 16;
  localparam int PLANE_SIZE  = MAX_HEIGHT * MAX_WIDTH;
  localparam int STORE_DEPTH = MAX_PLANES * PLANE_SIZE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int PLANE_W = 2;
  localparam int COORD_W = 7;
  localparam int PIX_W   = 8;
  localparam int SLOT_W  = 4;
  localparam int DIM_W   = 8;
  localparam int NC_W    = 2;
  localparam int NB_W    = 5;
  localparam int NORM_W  = 16;
  localparam int IDX_W   = 20;
  localparam int DIV_W   = COORD_W + DIM_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - NORM_W - IDX_W;

  // Request queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int REG_W   = 3;
  localparam logic [REG_W-1:0] REG_IN_WIDTH      = 3'd0;
  localparam logic [REG_W-1:0] REG_IN_HEIGHT     = 3'd1;
  localparam logic [REG_W-1:0] REG_OUT_WIDTH     = 3'd2;
  localparam logic [REG_W-1:0] REG_OUT_HEIGHT    = 3'd3;
  localparam logic [REG_W-1:0] REG_CHANNEL_COUNT = 3'd4;
  localparam logic [REG_W-1:0] REG_BATCH_COUNT   = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_DROP,
    KIND_SERVE
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [PLANE_W-1:0]  plane;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [PIX_W-1:0]    pixel;
    logic [SLOT_W-1:0]   slot;
  } item_t;

  // Sizes after clamping into their legal ranges
  typedef struct packed {
    logic [DIM_W-1:0] iw;
    logic [DIM_W-1:0] ih;
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] oh;
    logic [NC_W-1:0]  nc;
    logic [NB_W-1:0]  nb;
  } cfg_t;

  function automatic logic [DIM_W-1:0] sat_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(logic [PLANE_W-1:0] p,
                                                   logic [COORD_W-1:0] r,
                                                   logic [COORD_W-1:0] c);
    return ADDR_W'(p) * ADDR_W'(PLANE_SIZE) + ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
  endfunction

endpackage

/* hw/rtl/nnrn_ram.sv */
`timescale 1ns / 1ps

module nnrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/nnrn_front.sv */
`timescale 1ns / 1ps

module nnrn_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [nnrn_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  nnrn_pkg::cfg_t                cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output nnrn_pkg::item_t               q_item
);
  import nnrn_pkg::*;

  logic [PLANE_W-1:0] plane;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [PIX_W-1:0]   pixel;
  logic [SLOT_W-1:0]  slot;
  logic               in_store;
  logic               out_of_range;

  assign plane = s_tdata[PLANE_W-1:0];
  assign row   = s_tdata[PLANE_W +: COORD_W];
  assign col   = s_tdata[PLANE_W+COORD_W +: COORD_W];
  assign pixel = s_tdata[PLANE_W+2*COORD_W +: PIX_W];
  assign slot  = s_tdata[PLANE_W+2*COORD_W+PIX_W +: SLOT_W];

  assign in_store = (32'(plane) < MAX_PLANES) && (32'(row) < MAX_HEIGHT)
                 && (32'(col) < MAX_WIDTH);

  assign out_of_range = (NB_W'(slot) >= cfg.nb) || (plane >= cfg.nc)
                     || (DIM_W'(row) >= cfg.oh) || (DIM_W'(col) >= cfg.ow);

  assign s_tready = !q_full;

  always_comb begin
    q_item.plane = plane;
    q_item.row   = row;
    q_item.col   = col;
    q_item.pixel = pixel;
    q_item.slot  = slot;
    if (s_tuser == OP_WRITE) begin
      q_item.kind = KIND_WRITE;
    end else if (out_of_range) begin
      q_item.kind = KIND_DROP;
    end else begin
      q_item.kind = KIND_SERVE;
    end
    // stray writes outside the store are dropped here
    q_push = s_tvalid && s_tready && ((s_tuser == OP_READ) || in_store);
  end

endmodule

/* hw/rtl/nnrn_queue.sv */
`timescale 1ns / 1ps

module nnrn_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  nnrn_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output nnrn_pkg::item_t pop_item
);
  import nnrn_pkg::*;

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
                                  count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of bounds");

endmodule

/* hw/rtl/nnrn_back.sv */
`timescale 1ns / 1ps

module nnrn_back (
  input  logic                            clk,
  input  logic                            rst,
  input  nnrn_pkg::cfg_t                  cfg,
  input  logic                            q_valid,
  input  nnrn_pkg::item_t                 q_item,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [nnrn_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser
);
  import nnrn_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);
  localparam int HW_W   = 2 * DIM_W;
  localparam int BASE_W = SLOT_W + NC_W + 1;
  localparam int PROD_W = BASE_W + HW_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_RD,
    S_OUT
  } state_t;

  state_t              state;
  item_t               cur;
  logic [CNT_W-1:0]    cnt;
  logic [DIV_W-1:0]    num_y;
  logic [DIV_W-1:0]    num_x;
  logic [DIM_W-1:0]    rem_y;
  logic [DIM_W-1:0]    rem_x;
  logic [HW_W-1:0]     hw;
  logic [DIV_W-1:0]    rw;
  logic [BASE_W-1:0]   base;
  logic [PROD_W-1:0]   prod;
  logic [IDX_W-1:0]    idx;

  logic                out_free;
  logic                out_load;
  logic [DIM_W:0]      sh_y;
  logic [DIM_W:0]      sh_x;
  logic                ge_y;
  logic                ge_x;
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [PIX_W-1:0]    ram_rdata;

  assign out_free = !m_tvalid || m_tready;

  // one restoring step on each coordinate
  assign sh_y = {rem_y, num_y[DIV_W-1]};
  assign sh_x = {rem_x, num_x[DIV_W-1]};
  assign ge_y = sh_y >= {1'b0, cfg.oh};
  assign ge_x = sh_x >= {1'b0, cfg.ow};

  always_comb begin
    q_pop     = q_valid && (state == S_IDLE) && ((q_item.kind != KIND_DROP) || out_free);
    ram_we    = q_pop && (q_item.kind == KIND_WRITE);
    ram_waddr = store_addr(q_item.plane, q_item.row, q_item.col);
    ram_re    = (state == S_RD);
    ram_raddr = store_addr(cur.plane, num_y[COORD_W-1:0], num_x[COORD_W-1:0]);
    // output register takes a new result this cycle
    out_load  = (q_pop && (q_item.kind == KIND_DROP)) || ((state == S_OUT) && out_free);
  end

  nnrn_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_item.pixel),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_item.kind)
              KIND_DROP: begin
                m_tuser  <= 1'b1;
                m_tdata  <= '0;
              end
              KIND_SERVE: begin
                cur   <= q_item;
                state <= S_MUL;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          num_y <= DIV_W'(cur.row) * DIV_W'(cfg.ih);
          num_x <= DIV_W'(cur.col) * DIV_W'(cfg.iw);
          rw    <= DIV_W'(cur.row) * DIV_W'(cfg.ow);
          hw    <= HW_W'(cfg.oh) * HW_W'(cfg.ow);
          base  <= BASE_W'(cur.slot) * BASE_W'(cfg.nc) + BASE_W'(cur.plane);
          rem_y <= '0;
          rem_x <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem_y <= ge_y ? DIM_W'(sh_y - {1'b0, cfg.oh}) : sh_y[DIM_W-1:0];
          rem_x <= ge_x ? DIM_W'(sh_x - {1'b0, cfg.ow}) : sh_x[DIM_W-1:0];
          num_y <= {num_y[DIV_W-2:0], ge_y};
          num_x <= {num_x[DIV_W-2:0], ge_x};
          if (cnt == '0) begin
            prod <= PROD_W'(base) * PROD_W'(hw);
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          idx   <= IDX_W'(prod) + IDX_W'(rw) + IDX_W'(cur.col);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tuser  <= 1'b0;
            // v * 257 is the byte repeated
            m_tdata  <= {OUT_PAD_W'(0), idx, ram_rdata, ram_rdata};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_dropped_empty: assert property (@(posedge clk) disable iff (rst)
                                    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("dropped result carries data");
  a_port_conflict: assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("store written and read in one cycle");
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
                               (state == S_DIV && cnt != CNT_LAST) |=> (state == S_DIV))
    else $error("divider left early");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
                               (state != S_IDLE) |-> !q_pop)
    else $error("queue popped while busy");

endmodule

/* hw/rtl/nearest_neighbor_resize_normalize_top.sv */
// Write requests: popped from the queue into the frame store; one per cycle while the back end is idle.
// Pixel requests pass the queue, the multiply state, 15 restoring divider steps, the store read
//   and the output load before m_tvalid; the back end takes no new request from the queue until
//   the current one has been output. Out-of-range requests go from the queue to the output register.
// Reset (rst, synchronous): queue and output emptied, size registers back to
//   128/128/128/128/3/1. Frame store content is undefined until written; no clearing.
`timescale 1ns / 1ps

module nearest_neighbor_resize_normalize_top (
  input  logic                             clk,
  input  logic                             rst,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // plane[1:0] row[8:2] col[15:9] pixel_in[23:16] batch_slot[27:24], zero above
  input  logic [nnrn_pkg::IN_DATA_W-1:0]   s_tdata,
  // op
  input  logic                             s_tuser,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pixel_norm[15:0] dest_index[35:16], zero above
  output logic [nnrn_pkg::OUT_DATA_W-1:0]  m_tdata,
  // dropped
  output logic                             m_tuser,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nnrn_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import nnrn_pkg::*;

  logic [DIM_W-1:0] in_width;
  logic [DIM_W-1:0] in_height;
  logic [DIM_W-1:0] out_width;
  logic [DIM_W-1:0] out_height;
  logic [NC_W-1:0]  channel_count;
  logic [NB_W-1:0]  batch_count;

  logic [REG_W-1:0] reg_sel;
  logic             reg_wr;
  cfg_t             cfg;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  item_t            push_item;
  item_t            pop_item;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width      <= DIM_W'(128);
      in_height     <= DIM_W'(128);
      out_width     <= DIM_W'(128);
      out_height    <= DIM_W'(128);
      channel_count <= NC_W'(3);
      batch_count   <= NB_W'(1);
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_IN_WIDTH:      in_width      <= pwdata[DIM_W-1:0];
        REG_IN_HEIGHT:     in_height     <= pwdata[DIM_W-1:0];
        REG_OUT_WIDTH:     out_width     <= pwdata[DIM_W-1:0];
        REG_OUT_HEIGHT:    out_height    <= pwdata[DIM_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[NC_W-1:0];
        REG_BATCH_COUNT:   batch_count   <= pwdata[NB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IN_WIDTH:      prdata = 32'(in_width);
      REG_IN_HEIGHT:     prdata = 32'(in_height);
      REG_OUT_WIDTH:     prdata = 32'(out_width);
      REG_OUT_HEIGHT:    prdata = 32'(out_height);
      REG_CHANNEL_COUNT: prdata = 32'(channel_count);
      REG_BATCH_COUNT:   prdata = 32'(batch_count);
      default:           prdata = '0;
    endcase
  end

  // sizes clamped to 1..max; zero counts as one
  always_comb begin
    cfg.iw = sat_dim(in_width, DIM_W'(MAX_WIDTH));
    cfg.ih = sat_dim(in_height, DIM_W'(MAX_HEIGHT));
    cfg.ow = sat_dim(out_width, DIM_W'(MAX_WIDTH));
    cfg.oh = sat_dim(out_height, DIM_W'(MAX_HEIGHT));
    cfg.nc = NC_W'(sat_dim(DIM_W'(channel_count), DIM_W'(MAX_PLANES)));
    cfg.nb = NB_W'(sat_dim(DIM_W'(batch_count), DIM_W'(MAX_BATCH)));
  end

  // front: accept and classify each request
  nnrn_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // short queue decouples the front from the slow back end
  nnrn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  // back: store writes, coordinate division, lookup, result register
  nnrn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (pop_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
